/* rtl/core/cbir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbir_pkg
// shared types and constants of the cartridge bank and irq register block
// ----------------------------------------------------------------------------
package cbir_pkg;

   localparam int unsigned NUM_BANKS = 8;

   typedef logic [7:0] bank_type;

   typedef struct packed {
      logic        command;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  cycles;
   } req_payload_type;

   typedef struct packed {
      logic                         irq_line;
      logic                         counting;
      bank_type [NUM_BANKS-1:0]     banks;
   } rsp_payload_type;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // top address nibble decode
   localparam logic [3:0] PAGE_LATCH_0 = 4'h8;
   localparam logic [3:0] PAGE_LATCH_1 = 4'h9;
   localparam logic [3:0] PAGE_LATCH_2 = 4'hA;
   localparam logic [3:0] PAGE_LATCH_3 = 4'hB;
   localparam logic [3:0] PAGE_ENABLE  = 4'hC;
   localparam logic [3:0] PAGE_IRQ_ACK = 4'hD;
   localparam logic [3:0] PAGE_SELECT  = 4'hE;
   localparam logic [3:0] PAGE_BANK    = 4'hF;

   localparam logic [16:0] COUNT_LIMIT = 17'h0FFFF;

endpackage

/* rtl/core/cbir_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbir channel interfaces
// valid/ready channels for request and response transfers
// ----------------------------------------------------------------------------
interface cbir_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  data;
   logic [7:0]  cycles;

   modport source (output valid, command, address, data, cycles, input ready);
   modport sink   (input valid, command, address, data, cycles, output ready);
endinterface

interface cbir_rsp_if;
   logic       valid;
   logic       ready;
   logic       irq_line;
   logic       counting;
   logic [7:0] bank_zero;
   logic [7:0] bank_one;
   logic [7:0] bank_two;
   logic [7:0] bank_three;
   logic [7:0] bank_four;
   logic [7:0] bank_five;
   logic [7:0] bank_six;
   logic [7:0] bank_seven;

   modport source (output valid, irq_line, counting, bank_zero, bank_one, bank_two,
                   bank_three, bank_four, bank_five, bank_six, bank_seven,
                   input ready);
   modport sink   (input valid, irq_line, counting, bank_zero, bank_one, bank_two,
                   bank_three, bank_four, bank_five, bank_six, bank_seven,
                   output ready);
endinterface

/* rtl/core/cbir_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbir_in_stage
// input register: holds one request transfer until the core consumes it
// ----------------------------------------------------------------------------
module cbir_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   cbir_req_if.sink                 req_chan,
   input  logic                     advance,
   output logic                     item_valid,
   output cbir_pkg::req_payload_type item
);

   logic                      valid_ff;
   logic                      valid_in;
   cbir_pkg::req_payload_type item_ff;
   logic                      take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.command <= req_chan.command;
         item_ff.address <= req_chan.address;
         item_ff.data    <= req_chan.data;
         item_ff.cycles  <= req_chan.cycles;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/cbir_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbir_core
// bus write decode, irq cycle counter and bank registers
// ----------------------------------------------------------------------------
module cbir_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  cbir_pkg::req_payload_type item,
   output cbir_pkg::rsp_payload_type status_in
);

   logic [15:0]                              latch_ff, latch_in;
   logic [16:0]                              count_ff, count_in;
   logic                                     enable_ff, enable_in;
   logic                                     irq_ff, irq_in;
   logic [2:0]                               select_ff, select_in;
   cbir_pkg::bank_type [cbir_pkg::NUM_BANKS-1:0] banks_ff, banks_in;
   logic [3:0]                               nib;
   logic [16:0]                              sum;

   assign nib = item.data[3:0];
   assign sum = count_ff + {9'b0, item.cycles};

   always_comb begin
      latch_in  = latch_ff;
      count_in  = count_ff;
      enable_in = enable_ff;
      irq_in    = irq_ff;
      select_in = select_ff;
      banks_in  = banks_ff;
      if (fire) begin
         if (item.command == cbir_pkg::CMD_TICK) begin
            if (enable_ff) begin
               count_in = sum;
               if (sum >= cbir_pkg::COUNT_LIMIT) begin
                  enable_in = 1'b0;
                  count_in  = {1'b0, latch_ff};
                  irq_in    = 1'b1;
               end
            end
         end else begin
            case (item.address[15:12])
               cbir_pkg::PAGE_LATCH_0: begin
                  latch_in[3:0] = nib;
               end
               cbir_pkg::PAGE_LATCH_1: begin
                  latch_in[7:4] = nib;
               end
               cbir_pkg::PAGE_LATCH_2: begin
                  latch_in[11:8] = nib;
               end
               cbir_pkg::PAGE_LATCH_3: begin
                  latch_in[15:12] = nib;
               end
               cbir_pkg::PAGE_ENABLE: begin
                  enable_in = (nib != 4'd0);
                  if (nib != 4'd0) begin
                     count_in = {1'b0, latch_ff};
                  end
                  irq_in = 1'b0;
               end
               cbir_pkg::PAGE_IRQ_ACK: begin
                  irq_in = 1'b0;
               end
               cbir_pkg::PAGE_SELECT: begin
                  select_in = item.data[2:0];
               end
               cbir_pkg::PAGE_BANK: begin
                  banks_in[select_ff] = item.data;
               end
               default: begin
                  // low addresses are ignored
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff  <= '0;
         count_ff  <= '0;
         enable_ff <= 1'b0;
         irq_ff    <= 1'b0;
         select_ff <= '0;
         banks_ff  <= '0;
      end else begin
         latch_ff  <= latch_in;
         count_ff  <= count_in;
         enable_ff <= enable_in;
         irq_ff    <= irq_in;
         select_ff <= select_in;
         banks_ff  <= banks_in;
      end
   end

   assign status_in.irq_line = irq_in;
   assign status_in.counting = enable_in;
   assign status_in.banks    = banks_in;

endmodule

/* rtl/core/cbir_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbir_out_stage
// response register: holds the state view after each item until transferred
// ----------------------------------------------------------------------------
module cbir_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  cbir_pkg::rsp_payload_type status_in,
   output logic                      slot_free,
   cbir_rsp_if.source                rsp_chan
);

   logic                      valid_ff;
   logic                      valid_in;
   cbir_pkg::rsp_payload_type status_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.irq_line   = status_ff.irq_line;
   assign rsp_chan.counting   = status_ff.counting;
   assign rsp_chan.bank_zero  = status_ff.banks[0];
   assign rsp_chan.bank_one   = status_ff.banks[1];
   assign rsp_chan.bank_two   = status_ff.banks[2];
   assign rsp_chan.bank_three = status_ff.banks[3];
   assign rsp_chan.bank_four  = status_ff.banks[4];
   assign rsp_chan.bank_five  = status_ff.banks[5];
   assign rsp_chan.bank_six   = status_ff.banks[6];
   assign rsp_chan.bank_seven = status_ff.banks[7];

endmodule

/* rtl/core/cartridge_bank_irq_registers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_irq_registers
// cartridge mapper irq cycle counter and eight bank registers
// ----------------------------------------------------------------------------
// req_chan carries one item per transfer: a cpu bus write (address, data) or
// a tick of some cpu cycles. rsp_chan returns exactly one item per request:
// the irq level, the counter enable and all eight bank registers as they
// stand after that request has been applied.
// a transferred request waits in the input register; once the response
// register is free it is applied to the state and loaded there, i.e. two
// register stages from request to response. throughput: one item per cycle
// while rsp_chan.ready is held high, set by the single pass through the
// decode and the 17 bit counter add and compare between the two registers.
// reset clears the latch, counter, flags, bank select and all bank
// registers, and empties both stages. when the receiver holds rsp_chan.ready
// low the response register keeps its item, the input register fills, and
// req_chan.ready then drops until the response is transferred.
// ----------------------------------------------------------------------------
module cartridge_bank_irq_registers (
   input  logic       clock,
   input  logic       reset,
   cbir_req_if.sink   req_chan,
   cbir_rsp_if.source rsp_chan
);

   logic                      item_valid;
   cbir_pkg::req_payload_type item;
   cbir_pkg::rsp_payload_type status_in;
   logic                      slot_free;
   logic                      advance;

   assign advance = item_valid && slot_free;

   cbir_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   cbir_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .status_in (status_in)
   );

   cbir_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .status_in (status_in),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // irq can only be raised with the counter stopped, and enabling clears it
   assert property (@(posedge clock) disable iff (reset)
                    rsp_chan.valid |-> !(rsp_chan.irq_line && rsp_chan.counting))
      else $error("irq and counting both set");

   // full input stage with blocked response must stall requests
   assert property (@(posedge clock) disable iff (reset)
                    item_valid && !slot_free |-> !req_chan.ready)
      else $error("request taken while pipeline blocked");

   // an item moving on always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
                    advance |=> rsp_chan.valid)
      else $error("item lost between stages");

endmodule

/* bench/cartridge_bank_irq_registers_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_irq_registers_tb
// self-checking bench for the mapper irq counter and bank registers: bus
// writes and cycle ticks go in over req_chan, and every response is checked
// against a cycle-free prediction of latch, counter, irq and bank state, with
// bursty input, a stalling receiver and one long receiver hold-off
// ----------------------------------------------------------------------------
module cartridge_bank_irq_registers_tb;

   logic clock;
   logic reset;

   cbir_req_if req_chan ();
   cbir_rsp_if rsp_chan ();

   cartridge_bank_irq_registers u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted mapper state
   logic [15:0]        latch_value;
   logic [16:0]        count_value;
   logic               count_enable;
   logic               irq_flag;
   logic [2:0]         selected_bank;
   cbir_pkg::bank_type bank_value [cbir_pkg::NUM_BANKS];

   cbir_pkg::rsp_payload_type expected_snapshots [$];

   int   error_count;
   int   hold_off_cycles;
   logic stalls_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[cartridge_bank_irq_registers] ERROR");
      $finish;
   end

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   // apply one accepted transfer to the predicted state and queue the view
   function automatic void apply_mapper_item(input cbir_pkg::req_payload_type item);
      cbir_pkg::rsp_payload_type view;
      logic [3:0] nib;
      nib = item.data[3:0];
      if (item.command == cbir_pkg::CMD_TICK) begin
         if (count_enable) begin
            count_value = count_value + {9'd0, item.cycles};
            if (count_value >= cbir_pkg::COUNT_LIMIT) begin
               count_enable = 1'b0;
               count_value  = {1'b0, latch_value};
               irq_flag     = 1'b1;
            end
         end
      end else if (item.address[15]) begin
         case (item.address[15:12])
            cbir_pkg::PAGE_LATCH_0: latch_value[3:0]   = nib;
            cbir_pkg::PAGE_LATCH_1: latch_value[7:4]   = nib;
            cbir_pkg::PAGE_LATCH_2: latch_value[11:8]  = nib;
            cbir_pkg::PAGE_LATCH_3: latch_value[15:12] = nib;
            cbir_pkg::PAGE_ENABLE: begin
               count_enable = (nib != 4'd0);
               if (count_enable) begin
                  count_value = {1'b0, latch_value};
               end
               irq_flag = 1'b0;
            end
            cbir_pkg::PAGE_IRQ_ACK: irq_flag = 1'b0;
            cbir_pkg::PAGE_SELECT:  selected_bank = item.data[2:0];
            default:                bank_value[selected_bank] = item.data;
         endcase
      end
      view.irq_line = irq_flag;
      view.counting = count_enable;
      for (int i = 0; i < cbir_pkg::NUM_BANKS; i++) begin
         view.banks[i] = bank_value[i];
      end
      expected_snapshots.push_back(view);
   endfunction

   function automatic cbir_pkg::req_payload_type make_write(input logic [15:0] addr,
                                                             input logic [7:0] value);
      cbir_pkg::req_payload_type item;
      item.command = cbir_pkg::CMD_WRITE;
      item.address = addr;
      item.data    = value;
      item.cycles  = 8'($urandom);
      return item;
   endfunction

   function automatic cbir_pkg::req_payload_type make_tick(input logic [7:0] cyc);
      cbir_pkg::req_payload_type item;
      item.command = cbir_pkg::CMD_TICK;
      item.address = 16'($urandom);
      item.data    = 8'($urandom);
      item.cycles  = cyc;
      return item;
   endfunction

   // mostly decoded writes and ticks, latch biased close to the limit
   function automatic cbir_pkg::req_payload_type random_item();
      int unsigned roll;
      int unsigned pick;
      logic [7:0]  value;
      logic [3:0]  page;
      roll  = $urandom_range(0, 99);
      value = 8'($urandom);
      if (roll < 40) begin
         if ($urandom_range(0, 3) == 0) begin
            return make_tick(8'($urandom_range(0, 3)));
         end
         return make_tick(8'($urandom));
      end
      if (roll < 45) begin
         return make_write(16'($urandom_range(0, 16'h7FFF)), value);
      end
      pick = $urandom_range(0, 9);
      case (pick)
         0: page = cbir_pkg::PAGE_LATCH_0;
         1: page = cbir_pkg::PAGE_LATCH_1;
         2: page = cbir_pkg::PAGE_LATCH_2;
         3: page = cbir_pkg::PAGE_LATCH_3;
         4, 5: page = cbir_pkg::PAGE_ENABLE;
         6: page = cbir_pkg::PAGE_IRQ_ACK;
         7: page = cbir_pkg::PAGE_SELECT;
         default: page = cbir_pkg::PAGE_BANK;
      endcase
      if ((page == cbir_pkg::PAGE_LATCH_2 || page == cbir_pkg::PAGE_LATCH_3
           || page == cbir_pkg::PAGE_LATCH_1) && $urandom_range(0, 3) != 0) begin
         value[3:0] = 4'hF;
      end
      if (page == cbir_pkg::PAGE_ENABLE && value[3:0] == 4'd0
          && $urandom_range(0, 4) != 0) begin
         value[3:0] = 4'($urandom_range(1, 15));
      end
      return make_write({page, 12'($urandom)}, value);
   endfunction

   task automatic send_item(input cbir_pkg::req_payload_type item);
      req_chan.valid   <= 1'b1;
      req_chan.command <= item.command;
      req_chan.address <= item.address;
      req_chan.data    <= item.data;
      req_chan.cycles  <= item.cycles;
      do @(posedge clock); while (!req_chan.ready);
      apply_mapper_item(item);
   endtask

   task automatic pause_sender(input int cycles_idle);
      req_chan.valid <= 1'b0;
      repeat (cycles_idle) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_snapshots.size() != 0);
   endtask

   task automatic test_ignored_writes();
      send_item(make_write(16'h0000, 8'h00));
      send_item(make_write(16'h7FFF, 8'hFF));
      send_item(make_tick(8'hFF));
      wait_for_results();
   endtask

   task automatic test_bank_registers();
      send_item(make_write({cbir_pkg::PAGE_BANK, 12'h000}, 8'hFF));
      send_item(make_write({cbir_pkg::PAGE_SELECT, 12'hFFF}, 8'hFF));
      send_item(make_write({cbir_pkg::PAGE_BANK, 12'hFFF}, 8'h5A));
      send_item(make_write({cbir_pkg::PAGE_SELECT, 12'h000}, 8'hF8));
      send_item(make_write({cbir_pkg::PAGE_BANK, 12'h123}, 8'h00));
      send_item(make_write({cbir_pkg::PAGE_SELECT, 12'h800}, 8'h03));
      send_item(make_write({cbir_pkg::PAGE_BANK, 12'h001}, 8'hA5));
      wait_for_results();
   endtask

   task automatic test_irq_counter();
      // upper data nibbles must not reach the latch
      send_item(make_write({cbir_pkg::PAGE_LATCH_0, 12'h000}, 8'hF0));
      send_item(make_write({cbir_pkg::PAGE_LATCH_1, 12'hFFF}, 8'h0F));
      send_item(make_write({cbir_pkg::PAGE_LATCH_2, 12'h555}, 8'hFF));
      send_item(make_write({cbir_pkg::PAGE_LATCH_3, 12'hAAA}, 8'h5F));
      send_item(make_write({cbir_pkg::PAGE_ENABLE, 12'h000}, 8'h01));
      send_item(make_tick(8'h0E));
      send_item(make_tick(8'h01));
      send_item(make_tick(8'hFF));
      send_item(make_write({cbir_pkg::PAGE_IRQ_ACK, 12'h000}, 8'h00));
      // count sitting on the limit fires on a zero-cycle tick
      send_item(make_write({cbir_pkg::PAGE_LATCH_0, 12'h000}, 8'h0F));
      send_item(make_write({cbir_pkg::PAGE_ENABLE, 12'hFFF}, 8'hF1));
      send_item(make_tick(8'h00));
      send_item(make_write({cbir_pkg::PAGE_ENABLE, 12'h000}, 8'h02));
      send_item(make_write({cbir_pkg::PAGE_ENABLE, 12'h000}, 8'hF0));
      wait_for_results();
   endtask

   task automatic test_backpressure();
      stalls_on       = 1'b1;
      hold_off_cycles = 300;
      repeat (40) send_item(random_item());
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      cbir_pkg::req_payload_type item;
      int counted;
      int burst;
      for (int phase = 0; phase < 4; phase++) begin
         stalls_on = phase[0];
         counted   = 0;
         while (counted < 130) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               item = random_item();
               send_item(item);
               if (item.command == cbir_pkg::CMD_TICK || item.address[15]) begin
                  counted++;
               end
            end
            if ($urandom_range(0, 3) != 0) begin
               pause_sender($urandom_range(1, 6));
            end
         end
         wait_for_results();
      end
   endtask

   // receiver: free running, own stall pattern, or a counted hold-off
   initial begin : receiver
      int span;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            span            = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else if (!stalls_on) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      cbir_pkg::rsp_payload_type got;
      cbir_pkg::rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.irq_line = rsp_chan.irq_line;
         got.counting = rsp_chan.counting;
         got.banks[0] = rsp_chan.bank_zero;
         got.banks[1] = rsp_chan.bank_one;
         got.banks[2] = rsp_chan.bank_two;
         got.banks[3] = rsp_chan.bank_three;
         got.banks[4] = rsp_chan.bank_four;
         got.banks[5] = rsp_chan.bank_five;
         got.banks[6] = rsp_chan.bank_six;
         got.banks[7] = rsp_chan.bank_seven;
         if (expected_snapshots.size() == 0) begin
            note_failure("response transfer with nothing expected");
         end else begin
            want = expected_snapshots.pop_front();
            if (got.irq_line !== want.irq_line) begin
               note_failure($sformatf("irq_line expected %0b, got %0b",
                                      want.irq_line, got.irq_line));
            end
            if (got.counting !== want.counting) begin
               note_failure($sformatf("counting expected %0b, got %0b",
                                      want.counting, got.counting));
            end
            for (int i = 0; i < cbir_pkg::NUM_BANKS; i++) begin
               if (got.banks[i] !== want.banks[i]) begin
                  note_failure($sformatf("bank %0d expected %02h, got %02h",
                                         i, want.banks[i], got.banks[i]));
               end
            end
         end
      end
   end

   initial begin : stimulus
      error_count      = 0;
      hold_off_cycles  = 0;
      stalls_on        = 1'b0;
      latch_value      = '0;
      count_value      = '0;
      count_enable     = 1'b0;
      irq_flag         = 1'b0;
      selected_bank    = '0;
      for (int i = 0; i < cbir_pkg::NUM_BANKS; i++) begin
         bank_value[i] = '0;
      end
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.command = cbir_pkg::CMD_WRITE;
      req_chan.address = '0;
      req_chan.data    = '0;
      req_chan.cycles  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_writes();
      stalls_on = 1'b1;
      test_bank_registers();
      test_irq_counter();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_snapshots.size() == 0) begin
         $display("[cartridge_bank_irq_registers] OK");
      end else begin
         $display("[cartridge_bank_irq_registers] ERROR");
      end
      $finish;
   end

endmodule
